/* rtl/yuv2rgb_pkg.sv */
// ----------------------------------------------------------------------------
// YUYV to RGB package
// Shared widths, conversion coefficients and the types passed between the
// chroma unit, the pixel lanes and the top level.
// ----------------------------------------------------------------------------
package yuv2rgb_pkg;

	// Width of one video sample (Y, U, V, R, G or B).
	localparam int SAMPLE_W = 8;
	// Width of a signed channel sum; the blue sum reaches 137218.
	localparam int SUM_W = 19;
	// The channel sum is scaled down by 2^FRAC_W.
	localparam int FRAC_W = 8;

	// Fixed coefficients and offsets of the conversion.
	localparam logic signed [SUM_W-1:0] K_LUMA     = SUM_W'(298);
	localparam logic signed [SUM_W-1:0] K_RED_V    = SUM_W'(411);
	localparam logic signed [SUM_W-1:0] OFS_RED    = SUM_W'(57344);
	localparam logic signed [SUM_W-1:0] K_GREEN_U  = SUM_W'(101);
	localparam logic signed [SUM_W-1:0] K_GREEN_V  = SUM_W'(211);
	localparam logic signed [SUM_W-1:0] OFS_GREEN  = SUM_W'(34739);
	localparam logic signed [SUM_W-1:0] K_BLUE_U   = SUM_W'(519);
	localparam logic signed [SUM_W-1:0] OFS_BLUE   = SUM_W'(71117);
	localparam logic [SAMPLE_W-1:0]     SAMPLE_MAX = SAMPLE_W'(255);

	// Chroma contributions (with offsets) shared by both pixels of a pair.
	typedef struct packed {
		logic signed [SUM_W-1:0] red;
		logic signed [SUM_W-1:0] green;
		logic signed [SUM_W-1:0] blue;
	} chroma_terms_t;

	// One finished RGB888 pixel.
	typedef struct packed {
		logic [SAMPLE_W-1:0] red;
		logic [SAMPLE_W-1:0] green;
		logic [SAMPLE_W-1:0] blue;
	} rgb_t;

endpackage

/* rtl/yuv2rgb_chroma.sv */
// ----------------------------------------------------------------------------
// YUYV to RGB chroma unit
// Forms the U and V products plus offsets once per macropixel and registers
// them for both pixel lanes.
// ----------------------------------------------------------------------------
module yuv2rgb_chroma (
	input  logic                                clk,
	input  logic [yuv2rgb_pkg::SAMPLE_W-1:0]    chroma_blue,
	input  logic [yuv2rgb_pkg::SAMPLE_W-1:0]    chroma_red,
	output yuv2rgb_pkg::chroma_terms_t          terms_s1
);
	import yuv2rgb_pkg::*;

	logic signed [SUM_W-1:0] u_ext;
	logic signed [SUM_W-1:0] v_ext;
	chroma_terms_t           terms;

	assign u_ext = {{(SUM_W-SAMPLE_W){1'b0}}, chroma_blue};
	assign v_ext = {{(SUM_W-SAMPLE_W){1'b0}}, chroma_red};

	always_comb begin
		terms.red   = v_ext * K_RED_V - OFS_RED;
		terms.green = OFS_GREEN - u_ext * K_GREEN_U - v_ext * K_GREEN_V;
		terms.blue  = u_ext * K_BLUE_U - OFS_BLUE;
	end

	// Payload register; no reset needed.
	always_ff @(posedge clk) begin
		terms_s1 <= terms;
	end

endmodule

/* rtl/yuv2rgb_lane.sv */
// ----------------------------------------------------------------------------
// YUYV to RGB pixel lane
// Scales one luma sample, adds the shared chroma terms and clamps each
// channel to the 8-bit range after the floor shift.
// ----------------------------------------------------------------------------
module yuv2rgb_lane (
	input  logic                                clk,
	input  logic [yuv2rgb_pkg::SAMPLE_W-1:0]    luma,
	input  yuv2rgb_pkg::chroma_terms_t          terms_s1,
	output yuv2rgb_pkg::rgb_t                   pixel
);
	import yuv2rgb_pkg::*;

	logic signed [SUM_W-1:0] luma_ext;
	logic signed [SUM_W-1:0] luma_term_s1;
	logic signed [SUM_W-1:0] sum_red;
	logic signed [SUM_W-1:0] sum_green;
	logic signed [SUM_W-1:0] sum_blue;

	// Floor of sum / 256 clamped to 0..255: a negative sum gives zero, a sum
	// at or above 65536 saturates, anything else is the middle byte.
	function automatic logic [SAMPLE_W-1:0] clamp_channel(input logic signed [SUM_W-1:0] sum);
		logic [SAMPLE_W-1:0] res;
		if (sum[SUM_W-1]) begin
			res = '0;
		end else if (|sum[SUM_W-2:FRAC_W+SAMPLE_W]) begin
			res = SAMPLE_MAX;
		end else begin
			res = sum[FRAC_W+SAMPLE_W-1:FRAC_W];
		end
		return res;
	endfunction

	assign luma_ext = {{(SUM_W-SAMPLE_W){1'b0}}, luma};

	always_ff @(posedge clk) begin
		luma_term_s1 <= luma_ext * K_LUMA;
	end

	assign sum_red   = luma_term_s1 + terms_s1.red;
	assign sum_green = luma_term_s1 + terms_s1.green;
	assign sum_blue  = luma_term_s1 + terms_s1.blue;

	always_comb begin
		pixel.red   = clamp_channel(sum_red);
		pixel.green = clamp_channel(sum_green);
		pixel.blue  = clamp_channel(sum_blue);
	end

endmodule

/* rtl/yuyv_to_rgb_converter.sv */
// ----------------------------------------------------------------------------
// YUYV 4:2:2 to RGB888 converter
// Converts one YUYV macropixel per transfer into two RGB888 pixels that
// share the macropixel's U and V samples.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake            | Payload
//  --------+----------------------+---------------------------------------------
//  input   | start, busy          | luma_first, chroma_blue, luma_second,
//          |                      | chroma_red
//  result  | done (one-cycle)     | first_red/green/blue, second_red/green/blue
//
// A macropixel is taken at every rising edge with start high and busy low.
// busy is never raised: the two-stage pipeline takes one macropixel per clock,
// set by the single product-and-sum path through each pixel lane.
// The result of an accepted transfer passes through the stage-1 registers and
// then the stage-2 merge register, and appears on the result ports with done.
// The receiver cannot hold results off, so nothing in the pipeline ever stalls.
// arst_n clears the valid flags only; payload registers are not reset.
//
module yuyv_to_rgb_converter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [yuv2rgb_pkg::SAMPLE_W-1:0]    luma_first,
	input  logic [yuv2rgb_pkg::SAMPLE_W-1:0]    chroma_blue,
	input  logic [yuv2rgb_pkg::SAMPLE_W-1:0]    luma_second,
	input  logic [yuv2rgb_pkg::SAMPLE_W-1:0]    chroma_red,
	output logic                                done,
	output logic [yuv2rgb_pkg::SAMPLE_W-1:0]    first_red,
	output logic [yuv2rgb_pkg::SAMPLE_W-1:0]    first_green,
	output logic [yuv2rgb_pkg::SAMPLE_W-1:0]    first_blue,
	output logic [yuv2rgb_pkg::SAMPLE_W-1:0]    second_red,
	output logic [yuv2rgb_pkg::SAMPLE_W-1:0]    second_green,
	output logic [yuv2rgb_pkg::SAMPLE_W-1:0]    second_blue
);
	import yuv2rgb_pkg::*;

	logic          accept;
	logic          valid_s1;
	logic          valid_s2;
	chroma_terms_t terms_s1;
	rgb_t          lane_first;
	rgb_t          lane_second;
	rgb_t          first_s2;
	rgb_t          second_s2;

	// The pipeline never fills up, so a transfer is always possible.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Stage 1: the chroma products are formed once and fed to both lanes,
	// while each lane registers its own luma product.
	yuv2rgb_chroma u_chroma (
		.clk         (clk),
		.chroma_blue (chroma_blue),
		.chroma_red  (chroma_red),
		.terms_s1    (terms_s1)
	);

	yuv2rgb_lane u_lane_first (
		.clk      (clk),
		.luma     (luma_first),
		.terms_s1 (terms_s1),
		.pixel    (lane_first)
	);

	yuv2rgb_lane u_lane_second (
		.clk      (clk),
		.luma     (luma_second),
		.terms_s1 (terms_s1),
		.pixel    (lane_second)
	);

	// Valid flags travel alongside the payload through both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	// Stage 2: the merge register gathers the two clamped pixels into one
	// result word, driven straight onto the result ports.
	always_ff @(posedge clk) begin
		first_s2  <= lane_first;
		second_s2 <= lane_second;
	end

	assign done         = valid_s2;
	assign first_red    = first_s2.red;
	assign first_green  = first_s2.green;
	assign first_blue   = first_s2.blue;
	assign second_red   = second_s2.red;
	assign second_green = second_s2.green;
	assign second_blue  = second_s2.blue;

	// done follows each transfer through the stage-1 and stage-2 valid flags,
	// provided no reset came in between.
	assert property (@(posedge clk) disable iff (!arst_n)
		($past(arst_n, 2) && $past(arst_n, 1)) |-> (done == $past(accept, 2)))
		else $error("result strobe does not follow the input transfer");

	// Equal luma samples in one macropixel must give two identical pixels,
	// which ties the two lanes and the shared chroma terms together.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(luma_first == luma_second, 2)) |->
		(first_red == second_red && first_green == second_green &&
		 first_blue == second_blue))
		else $error("lanes disagree on equal luma samples");

	// Black in (Y = 0) with neutral chroma must give black out on the first pixel.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(luma_first == '0 && luma_second == '0 &&
		               chroma_blue == 8'd128 && chroma_red == 8'd128, 2)) |->
		(first_red == '0 && first_green == '0 && first_blue == '0))
		else $error("black level not preserved");

endmodule
